FILE: src/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg
// Types and constants shared by the custody signal serializer modules.
// ----------------------------------------------------------------------------
package css_pkg;

  localparam int FIELD_BITS = 64;
  localparam int GROUP_BITS = 7;
  localparam int TYPE_BITS  = 4;
  localparam int REASON_BITS = 7;
  localparam int BYTE_BITS  = 8;

  localparam logic [TYPE_BITS-1:0] RECORD_TYPE_RESET = 4'd4;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_FILL  = 1'b1;

  typedef struct packed {
    logic                   op;
    logic                   succeeded;
    logic [REASON_BITS-1:0] reason_code;
    logic [FIELD_BITS-1:0]  fill_start;
    logic [FIELD_BITS-1:0]  fill_length;
    logic                   final_req;
  } cmd_item_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data_byte;
    logic                 run_last;
    logic                 record_last;
  } tx_item_t;

  // control into the digit shifter
  typedef struct packed {
    logic load;
    logic advance;
  } shift_ctrl_t;

  // status out of the digit shifter
  typedef struct packed {
    logic [GROUP_BITS-1:0] digit;
    logic                  lead_zero;
    logic                  last_digit;
  } shift_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_STAT,
    ST_DELTA,
    ST_LEN
  } css_state_t;

endpackage

FILE: src/css_digit_shifter.sv
// ----------------------------------------------------------------------------
// css_digit_shifter
// Shift register that walks a value one 7-bit group per cycle while advance
// is set, most significant first, flagging leading zero groups to be skipped.
// ----------------------------------------------------------------------------
module css_digit_shifter import css_pkg::*; #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  shift_ctrl_t           ctrl,
  input  logic [VALUE_BITS-1:0] load_value,
  output shift_stat_t           stat
);

  localparam int NUM_GROUPS = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int SHIFT_BITS = NUM_GROUPS * GROUP_BITS;
  localparam int CNT_BITS   = $clog2(NUM_GROUPS);

  logic [SHIFT_BITS-1:0] shreg;
  logic [CNT_BITS-1:0]   cnt;
  logic                  started;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      started <= 1'b0;
    end else if (ctrl.load) begin
      cnt     <= CNT_BITS'(NUM_GROUPS - 1);
      started <= 1'b0;
    end else if (ctrl.advance) begin
      cnt <= cnt - CNT_BITS'(1);
      if (!stat.lead_zero) begin
        started <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      shreg <= SHIFT_BITS'(load_value);
    end else if (ctrl.advance) begin
      shreg <= {shreg[SHIFT_BITS-GROUP_BITS-1:0], {GROUP_BITS{1'b0}}};
    end
  end

  always_comb begin
    stat.digit      = shreg[SHIFT_BITS-1 -: GROUP_BITS];
    stat.last_digit = (cnt == '0);
    stat.lead_zero  = !started && (stat.digit == '0) && (cnt != '0);
  end

endmodule

FILE: src/css_out_reg.sv
// ----------------------------------------------------------------------------
// css_out_reg
// One-entry output register between the byte source and the receiver.
// ----------------------------------------------------------------------------
module css_out_reg import css_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load_valid,
  input  tx_item_t load_item,
  output logic     load_ready,
  output logic     tx_valid,
  input  logic     tx_stall,
  output tx_item_t tx
);

  assign load_ready = !tx_valid || !tx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (load_ready) begin
      tx_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      tx <= load_item;
    end
  end

endmodule

FILE: src/custody_signal_sdnv_serializer.sv
// ----------------------------------------------------------------------------
// custody_signal_sdnv_serializer
// Serializes aggregate custody signals into a byte stream with SDNV fills.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_stall/cmd) takes one item at a time. A begin
//   item gives a header byte and a status byte; a fill item gives the SDNV of
//   the start offset from the previous fill end, then the SDNV of the length.
//   tx channel (tx_valid/tx_stall/tx) gives one byte per item; run_last marks
//   the last byte of a command, record_last that byte when final_req was set.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes record_type; always
//   ready, to be written only while idle.
// Timing:
//   A begin item passes through the header and status states back to idle
//   before the next accept. A fill item walks both values through the digit
//   shifter one 7-bit group per cycle while the receiver does not stall,
//   ceil(VALUE_BITS/7) groups each; leading zero groups give no byte.
//   The first byte reaches tx after the state and then the output register.
// Reset: synchronous; record_type returns to 4, last fill end to zero.
// A stalled receiver holds the output register; only leading zeros still shift.
// ----------------------------------------------------------------------------
module custody_signal_sdnv_serializer import css_pkg::*; #(
  parameter int VALUE_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  cmd_item_t            cmd,
  output logic                 tx_valid,
  input  logic                 tx_stall,
  output tx_item_t             tx,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TYPE_BITS-1:0] cfg_data
);

  css_state_t             state;
  css_state_t             state_next;
  logic [TYPE_BITS-1:0]   record_type;
  logic [VALUE_BITS-1:0]  last_fill_end;
  logic [VALUE_BITS-1:0]  len_hold;
  logic [BYTE_BITS-1:0]   status_byte;
  logic                   final_flag;

  logic                   accept;
  logic [VALUE_BITS-1:0]  start_v;
  logic [VALUE_BITS-1:0]  length_v;
  logic                   emit_valid;
  tx_item_t               emit_item;
  logic                   emit_ready;
  shift_ctrl_t            sh_ctrl;
  shift_stat_t            sh_stat;
  logic [VALUE_BITS-1:0]  sh_value;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && (state == ST_IDLE);
  assign start_v   = cmd.fill_start[VALUE_BITS-1:0];
  assign length_v  = cmd.fill_length[VALUE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      record_type   <= RECORD_TYPE_RESET;
      last_fill_end <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        record_type <= cfg_data;
      end
      if (accept) begin
        if (cmd.op == OP_BEGIN) begin
          last_fill_end <= '0;
        end else begin
          last_fill_end <= start_v + length_v - VALUE_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      len_hold    <= length_v;
      status_byte <= {cmd.succeeded, cmd.reason_code};
      final_flag  <= cmd.final_req;
    end
  end

  always_comb begin
    state_next      = state;
    emit_valid      = 1'b0;
    emit_item       = '0;
    sh_ctrl.load    = 1'b0;
    sh_ctrl.advance = 1'b0;
    sh_value        = start_v - last_fill_end;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd.op == OP_BEGIN) begin
            state_next = ST_HDR;
          end else begin
            sh_ctrl.load = 1'b1;
            state_next   = ST_DELTA;
          end
        end
      end
      ST_HDR: begin
        emit_valid          = 1'b1;
        emit_item.data_byte = {record_type, {(BYTE_BITS-TYPE_BITS){1'b0}}};
        if (emit_ready) begin
          state_next = ST_STAT;
        end
      end
      ST_STAT: begin
        emit_valid            = 1'b1;
        emit_item.data_byte   = status_byte;
        emit_item.run_last    = 1'b1;
        emit_item.record_last = final_flag;
        if (emit_ready) begin
          state_next = ST_IDLE;
        end
      end
      ST_DELTA, ST_LEN: begin
        sh_value = len_hold;
        if (sh_stat.lead_zero) begin
          sh_ctrl.advance = 1'b1;
        end else begin
          emit_valid          = 1'b1;
          emit_item.data_byte = {!sh_stat.last_digit, sh_stat.digit};
          if (state == ST_LEN && sh_stat.last_digit) begin
            emit_item.run_last    = 1'b1;
            emit_item.record_last = final_flag;
          end
          if (emit_ready) begin
            sh_ctrl.advance = 1'b1;
            if (sh_stat.last_digit) begin
              if (state == ST_DELTA) begin
                sh_ctrl.load = 1'b1;
                state_next   = ST_LEN;
              end else begin
                state_next = ST_IDLE;
              end
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  css_digit_shifter #(
    .VALUE_BITS(VALUE_BITS)
  ) u_shifter (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (sh_ctrl),
    .load_value (sh_value),
    .stat       (sh_stat)
  );

  css_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (emit_valid),
    .load_item  (emit_item),
    .load_ready (emit_ready),
    .tx_valid   (tx_valid),
    .tx_stall   (tx_stall),
    .tx         (tx)
  );

endmodule
